// ===== rtl/lj_pkg.sv =====
// Shared constants, register codes and fixed-point formats of the Lennard-Jones force block.
package lj_pkg;

    // Defaults and configuration port geometry
    localparam int DEF_DATA_WIDTH = 32;
    localparam int CFG_W          = 32;
    localparam int CFG_ADDR_W     = 2;

    // Fixed-point formats
    localparam int FRAC_W    = 16;  // Q16.16 fields
    localparam int SIG_SHIFT = 48;  // sigma^2 scaling ahead of the reciprocal
    localparam int FIX_W     = 64;  // Q32.32 intermediates
    localparam int FIX_FRAC  = 32;

    // Multiplier partitioning
    localparam int LIMB_W  = 32;
    localparam int MUL_LAT = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STRENGTH,
        REG_SIGMA_SQ,
        REG_INNER_SQ,
        REG_OUTER_SQ
    } t_cfg_reg;

    localparam logic [CFG_W-1:0] RST_STRENGTH = 32'd655360;
    localparam logic [CFG_W-1:0] RST_SIGMA_SQ = 32'd6553600;
    localparam logic [CFG_W-1:0] RST_INNER_SQ = 32'd3686400;
    localparam logic [CFG_W-1:0] RST_OUTER_SQ = 32'd40960000;

endpackage

// ===== rtl/lj_delay.sv =====
// Enable-gated delay line that carries side data alongside the arithmetic pipeline.
module lj_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// ===== rtl/lj_mul.sv =====
// Pipelined unsigned multiplier: limb products, partial-product sum, then shift and clip.
module lj_mul #(
    parameter int AW    = lj_pkg::FIX_W,
    parameter int BW    = lj_pkg::FIX_W,
    parameter int OW    = lj_pkg::FIX_W,
    parameter int SHIFT = lj_pkg::FIX_FRAC
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [OW-1:0] o_p
);

    import lj_pkg::*;

    localparam int NA   = (AW + LIMB_W - 1) / LIMB_W;
    localparam int NB   = (BW + LIMB_W - 1) / LIMB_W;
    localparam int AP   = NA * LIMB_W;
    localparam int BP   = NB * LIMB_W;
    localparam int PW   = AW + BW;
    localparam int SUMW = AP + BP;

    logic [AP-1:0]       a_pad;
    logic [BP-1:0]       b_pad;
    logic [2*LIMB_W-1:0] r_pp [NA*NB];
    logic [SUMW-1:0]     n_sum;
    logic [PW-1:0]       r_sum;
    logic [PW-1:0]       shifted;
    logic [OW-1:0]       n_out;
    logic [OW-1:0]       r_out;

    assign a_pad = AP'(i_a);
    assign b_pad = BP'(i_b);

    // stage 1: independent limb products
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // stage 2: align and add the partial products
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (SUMW'(r_pp[i*NB+j]) << ((i + j) * LIMB_W));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sum <= n_sum[PW-1:0];
        end
    end

    // stage 3: drop fraction bits, clip to all ones on overflow
    assign shifted = r_sum >> SHIFT;

    generate
        if (PW - SHIFT > OW) begin : g_clip
            assign n_out = (|shifted[PW-1:OW]) ? '1 : shifted[OW-1:0];
        end else begin : g_fit
            assign n_out = OW'(shifted);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_p = r_out;

endmodule

// ===== rtl/lj_div.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module lj_div #(
    parameter int NW = lj_pkg::FIX_W,
    parameter int DW = lj_pkg::FIX_W,
    parameter int QW = lj_pkg::FIX_W
) (
    input  logic          i_clk,
    input  logic          i_ce,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];

    logic [NW-1:0] n_rem [QW+1];
    logic [QW-1:0] n_quo [QW+1];
    logic          n_ovf;

    // quotient would not fit in QW bits
    assign n_ovf = CW'(i_num) >= (CW'(i_den) << QW);

    always_comb begin
        logic [CW-1:0] rem_ext;
        logic [CW-1:0] den_sh;
        n_rem[0] = i_num;
        n_quo[0] = '0;
        for (int k = 1; k <= QW; k++) begin
            rem_ext  = CW'(r_rem[k-1]);
            den_sh   = CW'(r_den[k-1]) << (QW - k);
            n_rem[k] = r_rem[k-1];
            n_quo[k] = r_quo[k-1];
            if (rem_ext >= den_sh) begin
                n_rem[k]        = NW'(rem_ext - den_sh);
                n_quo[k][QW-k]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= n_rem[0];
            r_den[0] <= i_den;
            r_quo[0] <= n_quo[0];
            r_ovf[0] <= n_ovf;
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= n_quo[k];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

// ===== rtl/lennard_jones_pair_force.sv =====
// Top level of the Lennard-Jones 12-6 pair force pipeline with distance band.
//
//   channel   signals                                   direction
//   input     i_in_valid, o_in_stall, i_delta_x/y       beat in: one displacement
//   output    o_out_valid, i_out_stall, o_force_x/y,    beat out: one force vector
//             o_in_band, o_saturated
//   config    i_cfg_we, i_cfg_addr, i_cfg_data          register write, no read-back
//
// One beat enters per cycle while o_in_stall is low. Most of the pipeline depth lies
// in the two long-division pipelines: the 64-step reciprocal of the squared distance
// and the DATA_WIDTH-step component divide.
// Reset (synchronous, active low) clears the valid bits and loads the register defaults.
// An output register plus one skid register part the sides; o_in_stall is the
// registered skid-full flag, so the whole pipeline holds only while both are occupied.
module lennard_jones_pair_force #(
    parameter int DATA_WIDTH = lj_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [lj_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lj_pkg::CFG_W-1:0]      i_cfg_data,
    // displacement beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]  i_delta_x,
    input  logic signed [DATA_WIDTH-1:0]  i_delta_y,
    // force beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [DATA_WIDTH-1:0]  o_force_x,
    output logic signed [DATA_WIDTH-1:0]  o_force_y,
    output logic                          o_in_band,
    output logic                          o_saturated
);

    import lj_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int SW   = 2 * W;                      // squared distance, Q.32
    localparam int CMPW = (SW > CFG_W + FRAC_W) ? SW : CFG_W + FRAC_W;
    localparam int NW_Y = CFG_W + SIG_SHIFT;          // sigma^2 * 2^48
    localparam int NW_C = FIX_W + W;                  // T * |d|
    localparam int C12W = CFG_W + 4;                  // 12 * strength

    // pipeline positions: register stage at which each value becomes available
    localparam int P_IN = 1;
    localparam int P_SQ = P_IN + MUL_LAT;
    localparam int P_S  = P_SQ + 1;
    localparam int P_Y  = P_S + FIX_W + 1;
    localparam int P_Y2 = P_Y + MUL_LAT;
    localparam int P_X  = P_Y2 + MUL_LAT;
    localparam int P_X2 = P_X + MUL_LAT;
    localparam int P_M  = P_X2 + 1;
    localparam int P_T  = P_M + MUL_LAT;
    localparam int P_P  = P_T + MUL_LAT;
    localparam int P_Q  = P_P + W + 1;
    localparam int LV   = P_Q - P_IN + 1;

    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    // ---------------------------------------------------------------- registers
    logic [CFG_W-1:0] r_strength, r_sigma_sq, r_inner_sq, r_outer_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= RST_STRENGTH;
            r_sigma_sq <= RST_SIGMA_SQ;
            r_inner_sq <= RST_INNER_SQ;
            r_outer_sq <= RST_OUTER_SQ;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_STRENGTH: r_strength <= i_cfg_data;
                REG_SIGMA_SQ: r_sigma_sq <= i_cfg_data;
                REG_INNER_SQ: r_inner_sq <= i_cfg_data;
                REG_OUTER_SQ: r_outer_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // Every stage advances together while the skid register is free.
    logic          ce;
    logic          r_skd_valid;
    logic [LV-1:0] r_vld;

    assign ce         = !r_skd_valid;
    assign o_in_stall = r_skd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LV-2:0], i_in_valid};
        end
    end

    // ---------------------------------------------------------------- magnitudes
    logic [W-1:0] n_ax, n_ay;
    logic [W-1:0] r_ax, r_ay;
    logic         r_nx, r_ny;

    assign n_ax = i_delta_x[W-1] ? (~$unsigned(i_delta_x) + 1'b1) : $unsigned(i_delta_x);
    assign n_ay = i_delta_y[W-1] ? (~$unsigned(i_delta_y) + 1'b1) : $unsigned(i_delta_y);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_nx <= i_delta_x[W-1];
            r_ny <= i_delta_y[W-1];
        end
    end

    // ---------------------------------------------------------------- squared distance
    logic [SW-1:0] sq_x, sq_y, r_s;

    lj_mul #(.AW(W), .BW(W), .OW(SW), .SHIFT(0)) u_sq_x (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_ax), .i_b(r_ax), .o_p(sq_x)
    );
    lj_mul #(.AW(W), .BW(W), .OW(SW), .SHIFT(0)) u_sq_y (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_ay), .i_b(r_ay), .o_p(sq_y)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s <= sq_x + sq_y;
        end
    end

    // band test on s; a zero distance inside the band also gives zero force
    logic [CMPW-1:0] s_ext, lo_ext, hi_ext;
    logic            n_band, n_skip, band_q, skip_q;

    assign s_ext  = CMPW'(r_s);
    assign lo_ext = CMPW'(r_inner_sq) << FRAC_W;
    assign hi_ext = CMPW'(r_outer_sq) << FRAC_W;
    assign n_band = (s_ext >= lo_ext) && (s_ext <= hi_ext);
    assign n_skip = !n_band || (r_s == '0);

    lj_delay #(.WIDTH(2), .DEPTH(P_Q - P_S)) u_dly_band (
        .i_clk(i_clk), .i_ce(ce), .i_data({n_band, n_skip}), .o_data({band_q, skip_q})
    );

    // ---------------------------------------------------------------- Y = sigma^2 / s
    logic [FIX_W-1:0] quo_y, y;
    logic             ovf_y;

    lj_div #(.NW(NW_Y), .DW(SW), .QW(FIX_W)) u_div_y (
        .i_clk(i_clk), .i_ce(ce),
        .i_num(NW_Y'(r_sigma_sq) << SIG_SHIFT), .i_den(r_s),
        .o_quo(quo_y), .o_ovf(ovf_y)
    );

    assign y = ovf_y ? '1 : quo_y;

    // ---------------------------------------------------------------- X = Y^3, X^2
    logic [FIX_W-1:0] y2, y_d, x, x_d, x2;

    lj_mul #(.AW(FIX_W), .BW(FIX_W), .OW(FIX_W), .SHIFT(FIX_FRAC)) u_mul_y2 (
        .i_clk(i_clk), .i_ce(ce), .i_a(y), .i_b(y), .o_p(y2)
    );
    lj_delay #(.WIDTH(FIX_W), .DEPTH(MUL_LAT)) u_dly_y (
        .i_clk(i_clk), .i_ce(ce), .i_data(y), .o_data(y_d)
    );
    lj_mul #(.AW(FIX_W), .BW(FIX_W), .OW(FIX_W), .SHIFT(FIX_FRAC)) u_mul_x (
        .i_clk(i_clk), .i_ce(ce), .i_a(y2), .i_b(y_d), .o_p(x)
    );
    lj_delay #(.WIDTH(FIX_W), .DEPTH(MUL_LAT)) u_dly_x (
        .i_clk(i_clk), .i_ce(ce), .i_data(x), .o_data(x_d)
    );
    lj_mul #(.AW(FIX_W), .BW(FIX_W), .OW(FIX_W), .SHIFT(FIX_FRAC)) u_mul_x2 (
        .i_clk(i_clk), .i_ce(ce), .i_a(x), .i_b(x), .o_p(x2)
    );

    // M = |X(1-X)|; repulsive when X >= 1.0
    logic             n_repel, r_repel, repel_q;
    logic [FIX_W-1:0] r_m;

    assign n_repel = |x_d[FIX_W-1:FIX_FRAC];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_repel <= n_repel;
            r_m     <= n_repel ? (x2 - x_d) : (x_d - x2);
        end
    end

    lj_delay #(.WIDTH(1), .DEPTH(P_Q - P_M)) u_dly_repel (
        .i_clk(i_clk), .i_ce(ce), .i_data(r_repel), .o_data(repel_q)
    );

    // ---------------------------------------------------------------- T = 12 C M
    logic [C12W-1:0]  c12;
    logic [FIX_W-1:0] t;

    assign c12 = (C12W'(r_strength) << 3) + (C12W'(r_strength) << 2);

    lj_mul #(.AW(FIX_W), .BW(C12W), .OW(FIX_W), .SHIFT(FRAC_W)) u_mul_t (
        .i_clk(i_clk), .i_ce(ce), .i_a(r_m), .i_b(c12), .o_p(t)
    );

    // ---------------------------------------------------------------- T |d| / s
    logic [W-1:0]    ax_d, ay_d;
    logic            nx_q, ny_q;
    logic [SW-1:0]   s_d;
    logic [NW_C-1:0] px, py;
    logic [W-1:0]    qx, qy;
    logic            ovf_x, ovf_y2;

    lj_delay #(.WIDTH(2 * W), .DEPTH(P_T - P_IN)) u_dly_mag (
        .i_clk(i_clk), .i_ce(ce), .i_data({r_ax, r_ay}), .o_data({ax_d, ay_d})
    );
    lj_delay #(.WIDTH(2), .DEPTH(P_Q - P_IN)) u_dly_sign (
        .i_clk(i_clk), .i_ce(ce), .i_data({r_nx, r_ny}), .o_data({nx_q, ny_q})
    );
    lj_delay #(.WIDTH(SW), .DEPTH(P_P - P_S)) u_dly_s (
        .i_clk(i_clk), .i_ce(ce), .i_data(r_s), .o_data(s_d)
    );

    lj_mul #(.AW(FIX_W), .BW(W), .OW(NW_C), .SHIFT(0)) u_mul_px (
        .i_clk(i_clk), .i_ce(ce), .i_a(t), .i_b(ax_d), .o_p(px)
    );
    lj_mul #(.AW(FIX_W), .BW(W), .OW(NW_C), .SHIFT(0)) u_mul_py (
        .i_clk(i_clk), .i_ce(ce), .i_a(t), .i_b(ay_d), .o_p(py)
    );

    lj_div #(.NW(NW_C), .DW(SW), .QW(W)) u_div_x (
        .i_clk(i_clk), .i_ce(ce), .i_num(px), .i_den(s_d), .o_quo(qx), .o_ovf(ovf_x)
    );
    lj_div #(.NW(NW_C), .DW(SW), .QW(W)) u_div_fy (
        .i_clk(i_clk), .i_ce(ce), .i_num(py), .i_den(s_d), .o_quo(qy), .o_ovf(ovf_y2)
    );

    // ---------------------------------------------------------------- sign and clip
    logic         neg_x, neg_y, clip_x, clip_y;
    logic [W-1:0] lim_x, lim_y, m_x, m_y;
    logic [W-1:0] n_fx, n_fy;
    logic         n_sat;

    always_comb begin
        neg_x  = repel_q ^ nx_q;
        neg_y  = repel_q ^ ny_q;
        lim_x  = neg_x ? LIM_NEG : LIM_POS;
        lim_y  = neg_y ? LIM_NEG : LIM_POS;
        clip_x = ovf_x || (qx > lim_x);
        clip_y = ovf_y2 || (qy > lim_y);
        m_x    = clip_x ? lim_x : qx;
        m_y    = clip_y ? lim_y : qy;
        n_fx   = neg_x ? (~m_x + 1'b1) : m_x;
        n_fy   = neg_y ? (~m_y + 1'b1) : m_y;
        n_sat  = clip_x || clip_y;
        if (skip_q) begin
            n_fx  = '0;
            n_fy  = '0;
            n_sat = 1'b0;
        end
    end

    // ---------------------------------------------------------------- output and skid
    logic         tail_valid, take;
    logic         r_out_valid;
    logic [W-1:0] r_out_fx, r_out_fy, r_skd_fx, r_skd_fy;
    logic         r_out_band, r_out_sat, r_skd_band, r_skd_sat;

    assign tail_valid = r_vld[LV-1];
    assign take       = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (ce) begin
            if (tail_valid) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skd_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end else if (take) begin
            r_skd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (tail_valid && (!r_out_valid || take)) begin
                r_out_fx   <= n_fx;
                r_out_fy   <= n_fy;
                r_out_band <= band_q;
                r_out_sat  <= n_sat;
            end else if (tail_valid) begin
                r_skd_fx   <= n_fx;
                r_skd_fy   <= n_fy;
                r_skd_band <= band_q;
                r_skd_sat  <= n_sat;
            end
        end else if (take) begin
            // drain the skid beat into the output register
            r_out_fx   <= r_skd_fx;
            r_out_fy   <= r_skd_fy;
            r_out_band <= r_skd_band;
            r_out_sat  <= r_skd_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_force_x   = $signed(r_out_fx);
    assign o_force_y   = $signed(r_out_fy);
    assign o_in_band   = r_out_band;
    assign o_saturated = r_out_sat;

endmodule
